FILE: rtl/axhm_pkg.sv
`default_nettype none

package axhm_pkg;

	// port and result widths
	localparam int RAW_W  = 16;
	localparam int ABS_W  = 16;
	localparam int HEAD_W = 9;
	localparam int MAG_W  = 15;

	// vectoring rotator: Q32 operands, 51-bit datapath, 36-bit angle
	localparam int ITERS = 34;
	localparam int FRAC  = 32;
	localparam int CW    = 51;
	localparam int ZW    = 36;

	// angle to whole degrees with pi taken as 3.14159
	localparam int DEG_W   = 7;
	localparam int DEG_MAX = 89;
	localparam longint unsigned DEG_NUM = 64'd18000000;
	localparam longint unsigned PI_NUM  = 64'd314159;

	// magnitude: floor(sqrt(sq * 1225^2)) / 2048
	localparam int SQ_W      = 32;
	localparam int SCALE_W   = 21;
	localparam logic [SCALE_W-1:0] MAG_SCALE = 21'd1500625;
	localparam int N_W       = 52;
	localparam int ROOT_W    = 26;
	localparam int MAG_SHIFT = ROOT_W - MAG_W;

	// pipeline depths of the two paths and the padding that lines them up
	localparam int CORDIC_LAT = ITERS + 2;
	localparam int SQRT_LAT   = 3 + ROOT_W;
	localparam int MAG_DLY    = CORDIC_LAT - SQRT_LAT;

	// signs of one item, carried alongside the datapath
	typedef struct packed {
		logic x_neg;
		logic x_zero;
		logic y_neg;
		logic y_zero;
	} axhm_sign_t;

	// arctan(2^-i) in Q32 radians, rounded to nearest
	function automatic logic [ZW-1:0] atan_q32(input int i);
		logic [ZW-1:0] v;
		case (i)
			0:  v = ZW'(64'd3373259426);
			1:  v = ZW'(64'd1991351318);
			2:  v = ZW'(64'd1052175346);
			3:  v = ZW'(64'd534100635);
			4:  v = ZW'(64'd268086748);
			5:  v = ZW'(64'd134174063);
			6:  v = ZW'(64'd67103403);
			7:  v = ZW'(64'd33553749);
			8:  v = ZW'(64'd16777131);
			9:  v = ZW'(64'd8388597);
			10: v = ZW'(64'd4194303);
			33: v = ZW'(64'd1);
			default: v = ZW'(64'd1 << (FRAC - i));
		endcase
		return v;
	endfunction

	// smallest Q32 angle that reaches m whole degrees
	function automatic logic [ZW-1:0] deg_thresh(input int m);
		longint unsigned p;
		p = 64'(m) * PI_NUM;
		p = p << FRAC;
		return ZW'((p + DEG_NUM - 64'd1) / DEG_NUM);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/axhm_cordic.sv
`default_nettype none

module axhm_cordic (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [axhm_pkg::ABS_W-1:0]  ax,
	input  wire logic [axhm_pkg::ABS_W-1:0]  ay,
	output logic      [axhm_pkg::DEG_W-1:0]  deg
);
	import axhm_pkg::*;

	logic signed [CW-1:0] x_in;
	logic signed [CW-1:0] y_in;
	logic signed [CW-1:0] x_src [ITERS];
	logic signed [CW-1:0] y_src [ITERS];
	logic signed [ZW-1:0] z_src [ITERS];
	logic signed [CW-1:0] x_nx  [ITERS];
	logic signed [CW-1:0] y_nx  [ITERS];
	logic signed [ZW-1:0] z_nx  [ITERS];
	logic signed [CW-1:0] x_s   [ITERS];
	logic signed [CW-1:0] y_s   [ITERS];
	logic signed [ZW-1:0] z_s   [ITERS];
	logic [DEG_MAX-1:0]   thermo;
	logic [DEG_MAX-1:0]   thermo_s35;
	logic [DEG_W-1:0]     deg_s36;

	// operands in Q32
	assign x_in = $signed(CW'({ax, {FRAC{1'b0}}}));
	assign y_in = $signed(CW'({ay, {FRAC{1'b0}}}));

	// each iteration takes the previous stage's registers
	always_comb begin
		x_src[0] = x_in;
		y_src[0] = y_in;
		z_src[0] = '0;
		for (int i = 1; i < ITERS; i++) begin
			x_src[i] = x_s[i-1];
			y_src[i] = y_s[i-1];
			z_src[i] = z_s[i-1];
		end
	end

	// one micro-rotation per stage, driving y towards zero
	always_comb begin
		for (int i = 0; i < ITERS; i++) begin
			if (!y_src[i][CW-1]) begin
				x_nx[i] = x_src[i] + (y_src[i] >>> i);
				y_nx[i] = y_src[i] - (x_src[i] >>> i);
				z_nx[i] = z_src[i] + $signed(atan_q32(i));
			end else begin
				x_nx[i] = x_src[i] - (y_src[i] >>> i);
				y_nx[i] = y_src[i] + (x_src[i] >>> i);
				z_nx[i] = z_src[i] - $signed(atan_q32(i));
			end
		end
	end

	// iteration registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ITERS; i++) begin
				x_s[i] <= x_nx[i];
				y_s[i] <= y_nx[i];
				z_s[i] <= z_nx[i];
			end
		end
	end

	// compare the angle against every whole-degree boundary, negative angles reach none
	always_comb begin
		for (int m = 0; m < DEG_MAX; m++) begin
			thermo[m] = (z_s[ITERS-1] >= $signed(deg_thresh(m + 1)));
		end
	end

	// thermometer code to degree count, capped by the number of boundaries
	always_ff @(posedge clk) begin
		if (en) begin
			thermo_s35 <= thermo;
			deg_s36    <= DEG_W'($countones(thermo_s35));
		end
	end

	assign deg = deg_s36;

endmodule

`default_nettype wire

FILE: rtl/axhm_isqrt.sv
`default_nettype none

module axhm_isqrt (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [axhm_pkg::ABS_W-1:0]  ax,
	input  wire logic [axhm_pkg::ABS_W-1:0]  ay,
	output logic      [axhm_pkg::MAG_W-1:0]  mag
);
	import axhm_pkg::*;

	localparam int TW = N_W + 1;

	logic [SQ_W-1:0]   xx_s1;
	logic [SQ_W-1:0]   yy_s1;
	logic [SQ_W-1:0]   sq_s2;
	logic [N_W-1:0]    n_s3;
	logic [N_W-1:0]    rem_src  [ROOT_W];
	logic [ROOT_W-1:0] root_src [ROOT_W];
	logic [N_W-1:0]    rem_nx   [ROOT_W];
	logic [ROOT_W-1:0] root_nx  [ROOT_W];
	logic [TW-1:0]     trial    [ROOT_W];
	logic [N_W-1:0]    rem_s    [ROOT_W];
	logic [ROOT_W-1:0] root_s   [ROOT_W];

	// squares, sum, then scale to the square of mm/s^2 times 2^22
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= SQ_W'(ax) * SQ_W'(ax);
			yy_s1 <= SQ_W'(ay) * SQ_W'(ay);
			sq_s2 <= xx_s1 + yy_s1;
			n_s3  <= N_W'(sq_s2) * N_W'(MAG_SCALE);
		end
	end

	// each root stage takes the previous stage's registers
	always_comb begin
		rem_src[0]  = n_s3;
		root_src[0] = '0;
		for (int j = 1; j < ROOT_W; j++) begin
			rem_src[j]  = rem_s[j-1];
			root_src[j] = root_s[j-1];
		end
	end

	// one root bit per stage, most significant first
	always_comb begin
		for (int j = 0; j < ROOT_W; j++) begin
			trial[j] = (TW'(root_src[j]) << (ROOT_W - j))
				+ (TW'(1) << (2 * (ROOT_W - 1 - j)));
			if ({1'b0, rem_src[j]} >= trial[j]) begin
				rem_nx[j]  = rem_src[j] - trial[j][N_W-1:0];
				root_nx[j] = root_src[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
			end else begin
				rem_nx[j]  = rem_src[j];
				root_nx[j] = root_src[j];
			end
		end
	end

	// root stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < ROOT_W; j++) begin
				rem_s[j]  <= rem_nx[j];
				root_s[j] <= root_nx[j];
			end
		end
	end

	// dropping 11 bits divides by 2048
	assign mag = root_s[ROOT_W-1][ROOT_W-1:MAG_SHIFT];

endmodule

`default_nettype wire

FILE: rtl/accel_xy_heading_magnitude.sv
`default_nettype none

// Converts one signed 16-bit X/Y accelerometer sample (2g full scale) per item into
// heading_deg, the truncated direction in whole degrees 0..359 counterclockwise from +X,
// and magnitude_mm, the truncated XY length in mm/s^2 (each axis scaled by 19600/32768).
// The block takes one item every cycle while in_stall is low. A result appears on
// out_valid once its item has passed one input register, 34 stages of the vectoring
// rotator, two stages that turn its angle into degrees, and the output register; the
// magnitude path (squares, scale and a 26-stage bit-per-stage square root) is padded to
// the same depth. A stall on the output freezes the pipeline only once the single skid
// entry behind the output register holds an item, and in_stall is high exactly while that
// entry is full. X zero gives 90 or 270, and a zero sample gives heading 0 and magnitude 0.
module accel_xy_heading_magnitude (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [axhm_pkg::RAW_W-1:0]  accel_x,
	input  wire logic signed [axhm_pkg::RAW_W-1:0]  accel_y,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic             [axhm_pkg::HEAD_W-1:0] heading_deg,
	output logic             [axhm_pkg::MAG_W-1:0]  magnitude_mm
);
	import axhm_pkg::*;

	logic               en;
	logic [ABS_W-1:0]   ax_abs;
	logic [ABS_W-1:0]   ay_abs;
	axhm_sign_t         sign_in;
	logic [ABS_W-1:0]   ax_s1;
	logic [ABS_W-1:0]   ay_s1;
	logic [CORDIC_LAT:0] vld_s;
	axhm_sign_t         sign_s [CORDIC_LAT+1];
	logic [DEG_W-1:0]   deg_end;
	logic [MAG_W-1:0]   mag_root;
	logic [MAG_W-1:0]   mag_s [MAG_DLY];
	axhm_sign_t         sign_end;
	logic [HEAD_W-1:0]  k;
	logic [HEAD_W-1:0]  head_end;
	logic               out_valid_q;
	logic               skid_full_q;
	logic [HEAD_W-1:0]  heading_q;
	logic [MAG_W-1:0]   magnitude_q;
	logic [HEAD_W-1:0]  skid_heading_q;
	logic [MAG_W-1:0]   skid_magnitude_q;

	// the pipeline moves whenever the skid entry is free
	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	// absolute values and signs, the most negative reading stays 32768
	assign ax_abs = accel_x[RAW_W-1] ? ABS_W'(-accel_x) : ABS_W'(accel_x);
	assign ay_abs = accel_y[RAW_W-1] ? ABS_W'(-accel_y) : ABS_W'(accel_y);
	assign sign_in.x_neg  = accel_x[RAW_W-1];
	assign sign_in.x_zero = (accel_x == '0);
	assign sign_in.y_neg  = accel_y[RAW_W-1];
	assign sign_in.y_zero = (accel_y == '0);

	// valid bits along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[CORDIC_LAT-1:0], in_valid};
		end
	end

	// input register and sign flags travelling with each item
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1     <= ax_abs;
			ay_s1     <= ay_abs;
			sign_s[0] <= sign_in;
			for (int j = 1; j <= CORDIC_LAT; j++) begin
				sign_s[j] <= sign_s[j-1];
			end
		end
	end

	axhm_cordic u_cordic (
		.clk (clk),
		.en  (en),
		.ax  (ax_s1),
		.ay  (ay_s1),
		.deg (deg_end)
	);

	axhm_isqrt u_isqrt (
		.clk (clk),
		.en  (en),
		.ax  (ax_s1),
		.ay  (ay_s1),
		.mag (mag_root)
	);

	// pad the magnitude to the depth of the heading path
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s[0] <= mag_root;
			for (int j = 1; j < MAG_DLY; j++) begin
				mag_s[j] <= mag_s[j-1];
			end
		end
	end

	// quadrant placement of the first-quadrant degrees
	assign sign_end = sign_s[CORDIC_LAT];
	assign k = sign_end.y_zero ? '0 : HEAD_W'(deg_end);

	always_comb begin
		if (sign_end.x_zero) begin
			if (sign_end.y_zero) begin
				head_end = '0;
			end else if (sign_end.y_neg) begin
				head_end = HEAD_W'(270);
			end else begin
				head_end = HEAD_W'(90);
			end
		end else if (!sign_end.x_neg) begin
			head_end = sign_end.y_neg ? HEAD_W'(359) - k : k;
		end else if (sign_end.y_zero) begin
			head_end = HEAD_W'(180);
		end else if (sign_end.y_neg) begin
			head_end = HEAD_W'(180) + k;
		end else begin
			head_end = HEAD_W'(179) - k;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= en && vld_s[CORDIC_LAT];
			end
		end else if (en && vld_s[CORDIC_LAT]) begin
			skid_full_q <= 1'b1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_full_q) begin
				heading_q   <= skid_heading_q;
				magnitude_q <= skid_magnitude_q;
			end else begin
				heading_q   <= head_end;
				magnitude_q <= mag_s[MAG_DLY-1];
			end
		end else if (!skid_full_q) begin
			skid_heading_q   <= head_end;
			skid_magnitude_q <= mag_s[MAG_DLY-1];
		end
	end

	assign out_valid    = out_valid_q;
	assign heading_deg  = heading_q;
	assign magnitude_mm = magnitude_q;

`ifndef SYNTHESIS
	// the skid entry only ever holds an item behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid entry full while output register empty");

	// the skid entry fills only when a waiting result was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_valid_q && out_stall))
		else $error("skid entry filled without an output stall");

	// an accepted item enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s[0])
		else $error("accepted item missing from the first stage");

	// headings stay within one turn
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> heading_q <= HEAD_W'(359))
		else $error("heading out of range");
`endif

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ROT_STEPS   = 34;
	localparam int TAIL_CYCLES = 60;

	// one expected result, with the sample that caused it for reporting
	typedef struct packed {
		logic signed [axhm_pkg::RAW_W-1:0] x;
		logic signed [axhm_pkg::RAW_W-1:0] y;
		logic        [axhm_pkg::HEAD_W-1:0] heading;
		logic        [axhm_pkg::MAG_W-1:0]  mag;
	} polar_t;

	logic                                    clk;
	logic                                    arst_n;
	logic                                    in_valid;
	logic                                    in_stall;
	logic signed [axhm_pkg::RAW_W-1:0]       accel_x;
	logic signed [axhm_pkg::RAW_W-1:0]       accel_y;
	logic                                    out_valid;
	logic                                    out_stall;
	logic        [axhm_pkg::HEAD_W-1:0]      heading_deg;
	logic        [axhm_pkg::MAG_W-1:0]       magnitude_mm;

	polar_t      expected_polar[$];
	longint      atan_tab[ROT_STEPS];
	int          mismatch_count;
	int          cycle_count;
	bit          src_idle_on;
	bit          sink_idle_on;
	int unsigned sink_hold;

	accel_xy_heading_magnitude u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.heading_deg  (heading_deg),
		.magnitude_mm (magnitude_mm)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// arctan(2^-i) in Q32 radians from the series, atan(1) as atan(1/2) + atan(1/3)
	task automatic build_atan_table();
		longint unsigned one, half, third, sum, t, p;
		int unsigned     i, k, sh;
		one   = 64'd1 << 60;
		half  = 64'd0;
		third = 64'd0;
		for (i = 1; i < ROT_STEPS; i++) begin
			sum = 64'd0;
			k   = 0;
			sh  = i;
			while (sh < 60) begin
				t = (one >> sh) / 64'(2 * k + 1);
				if (k[0] == 1'b0)
					sum = sum + t;
				else
					sum = sum - t;
				k++;
				sh = i * (2 * k + 1);
			end
			if (i == 1)
				half = sum;
			atan_tab[i] = longint'((sum + (64'd1 << 27)) >> 28);
		end
		p = one / 64'd3;
		k = 0;
		while (p != 64'd0) begin
			t = p / 64'(2 * k + 1);
			if (k[0] == 1'b0)
				third = third + t;
			else
				third = third - t;
			p = p / 64'd9;
			k++;
		end
		atan_tab[0] = longint'((half + third + (64'd1 << 27)) >> 28);
	endtask

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root, probe, rem;
		rem   = n;
		root  = 64'd0;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 64'd0) begin
			if (rem >= root + probe) begin
				rem  = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// whole degrees of atan(ay/ax) in the first quadrant, vectoring rotation in Q32
	function automatic int quadrant_deg(input int unsigned ax, input int unsigned ay);
		longint          xv, yv, z, dx, dy;
		longint unsigned deg;
		int              i;
		xv = longint'(ax) << 32;
		yv = longint'(ay) << 32;
		z  = 0;
		for (i = 0; i < ROT_STEPS; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv = xv + dx;
				yv = yv - dy;
				z  = z + atan_tab[i];
			end else begin
				xv = xv - dx;
				yv = yv + dy;
				z  = z - atan_tab[i];
			end
		end
		if (z < 0)
			z = 0;
		deg = ($unsigned(z) * 64'd18000000 / 64'd314159) >> 32;
		if (deg > 64'd89)
			deg = 64'd89;
		return int'(deg);
	endfunction

	// heading and scaled magnitude of one sample
	function automatic polar_t predict_polar(input logic signed [axhm_pkg::RAW_W-1:0] xs,
			input logic signed [axhm_pkg::RAW_W-1:0] ys);
		int              x, y, k, hd;
		int unsigned     ax, ay;
		longint unsigned sq, mag;
		polar_t          r;
		x   = xs;
		y   = ys;
		ax  = (x < 0) ? -x : x;
		ay  = (y < 0) ? -y : y;
		sq  = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
		mag = int_sqrt(sq * 64'd1500625) / 64'd2048;
		if (x == 0) begin
			if (y > 0)
				hd = 90;
			else if (y < 0)
				hd = 270;
			else
				hd = 0;
		end else begin
			k = (ay == 0) ? 0 : quadrant_deg(ax, ay);
			if (x > 0)
				hd = (y >= 0) ? k : 359 - k;
			else if (y > 0)
				hd = 179 - k;
			else if (y == 0)
				hd = 180;
			else
				hd = 180 + k;
		end
		r.x       = xs;
		r.y       = ys;
		r.heading = hd[axhm_pkg::HEAD_W-1:0];
		r.mag     = mag[axhm_pkg::MAG_W-1:0];
		return r;
	endfunction

	// cycle count and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// record accepted samples and compare each result with the oldest expectation
	always @(posedge clk) begin
		polar_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_polar.push_back(predict_polar(accel_x, accel_y));
			if (out_valid && !out_stall) begin
				if (expected_polar.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: heading %0d magnitude %0d",
							heading_deg, magnitude_mm);
				end else begin
					want = expected_polar.pop_front();
					if (heading_deg !== want.heading || magnitude_mm !== want.mag) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("x %0d y %0d: heading exp %0d got %0d, magnitude exp %0d got %0d",
								want.x, want.y, want.heading, heading_deg,
								want.mag, magnitude_mm);
					end
				end
			end
		end
	end

	// result side: random or long hold-off before each item
	initial begin : sink_ctrl
		int unsigned wait_cycles;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold != 0) begin
				wait_cycles = sink_hold;
				sink_hold   = 0;
			end else begin
				wait_cycles = sink_idle_on ? $urandom_range(0, 14) : 0;
			end
			if (wait_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// offer one sample and hold it until taken
	task automatic send_sample(input logic signed [axhm_pkg::RAW_W-1:0] x,
			input logic signed [axhm_pkg::RAW_W-1:0] y);
		int unsigned gap;
		gap = src_idle_on ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x  <= x;
		accel_y  <= y;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_polar.size() != 0)
			@(posedge clk);
	endtask

	// one random sample, weighted towards axes, extremes and degree boundaries
	task automatic random_sample(output logic signed [axhm_pkg::RAW_W-1:0] x,
			output logic signed [axhm_pkg::RAW_W-1:0] y);
		int unsigned kind, m;
		int          xi, yi;
		int          corner[6];
		real         rad, th;
		corner = '{-32768, -32767, -1, 0, 1, 32767};
		kind   = $urandom_range(0, 99);
		if (kind < 55) begin
			xi = $signed(16'($urandom()));
			yi = $signed(16'($urandom()));
		end else if (kind < 65) begin
			xi = int'($urandom_range(0, 128)) - 64;
			yi = int'($urandom_range(0, 128)) - 64;
		end else if (kind < 75) begin
			xi = $signed(16'($urandom()));
			yi = int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1) == 1) begin
				yi = xi;
				xi = int'($urandom_range(0, 2)) - 1;
			end
		end else if (kind < 85) begin
			xi = corner[$urandom_range(0, 5)];
			yi = corner[$urandom_range(0, 5)];
		end else begin
			// close to a whole degree, then jittered and flipped into a quadrant
			m   = $urandom_range(0, 89);
			rad = real'($urandom_range(50, 32000));
			th  = real'(m) * 3.14159 / 180.0;
			xi  = $rtoi(rad * $cos(th)) + int'($urandom_range(0, 2)) - 1;
			yi  = $rtoi(rad * $sin(th)) + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1) == 1)
				xi = -xi;
			if ($urandom_range(0, 1) == 1)
				yi = -yi;
		end
		x = xi[axhm_pkg::RAW_W-1:0];
		y = yi[axhm_pkg::RAW_W-1:0];
	endtask

	// axes, corners, zero and the steepest and shallowest angles
	task automatic test_directed();
		int xs[25];
		int ys[25];
		int i;
		xs = '{0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767, 1, -1, 1, -1,
			1, -1, 0, 0, 1, -1, 1, -1, 32767, -32768, 32767, -32768};
		ys = '{0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768, 1, -1, -1, 1,
			0, 0, 1, -1, 32767, 32767, -32768, -32768, 1, -1, -1, 1};
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		for (i = 0; i < 25; i++)
			send_sample(xs[i][axhm_pkg::RAW_W-1:0], ys[i][axhm_pkg::RAW_W-1:0]);
		wait_drain();
	endtask

	// long output hold-off while samples keep coming, so the input stalls
	task automatic test_backpressure();
		logic signed [axhm_pkg::RAW_W-1:0] x, y;
		int i;
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		sink_hold    = 300;
		for (i = 0; i < 120; i++) begin
			random_sample(x, y);
			send_sample(x, y);
		end
		wait_drain();
	endtask

	// random samples in segments with changing idle patterns on both sides
	task automatic test_random();
		logic signed [axhm_pkg::RAW_W-1:0] x, y;
		int seg, i;
		for (seg = 0; seg < 12; seg++) begin
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			for (i = 0; i < 105; i++) begin
				random_sample(x, y);
				send_sample(x, y);
			end
			if (seg % 4 == 3)
				wait_drain();
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		accel_x        <= '0;
		accel_y        <= '0;
		mismatch_count = 0;
		cycle_count    = 0;
		src_idle_on    = 1'b0;
		sink_idle_on   = 1'b0;
		sink_hold      = 0;
		build_atan_table();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_polar.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
